@@ hw/rtl/kli_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package kli_pkg;

    localparam int MAX_NODES_DEF = 64;
    localparam logic [31:0] FROZEN_STEP = 32'd5000;
    localparam int NODE_W = 224;

    typedef enum logic [1:0] {
        ACT_ADD   = 2'd0,
        ACT_QUERY = 2'd1,
        ACT_CLEAR = 2'd2,
        ACT_NONE  = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_DUP      = 3'd1,
        ST_FULL     = 3'd2,
        ST_FEW      = 3'd3,
        ST_RANGE    = 3'd4
    } status_t;

    typedef struct packed {
        logic [1:0]         action;
        logic [31:0]        key_tick;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [15:0] rot_w;
        logic signed [15:0] rot_x;
        logic signed [15:0] rot_y;
        logic signed [15:0] rot_z;
        logic [15:0]        view_angle;
    } req_t;

    typedef struct packed {
        logic [2:0]         status;
        logic signed [31:0] out_pos_x;
        logic signed [31:0] out_pos_y;
        logic signed [31:0] out_pos_z;
        logic signed [15:0] out_rot_w;
        logic signed [15:0] out_rot_x;
        logic signed [15:0] out_rot_y;
        logic signed [15:0] out_rot_z;
        logic [15:0]        out_view_angle;
    } rsp_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_ADD_RD,
        S_ADD_CHK,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_INS,
        S_Q_RD,
        S_Q_CHK,
        S_Q_RDA,
        S_Q_RDB,
        S_Q_LDB,
        S_DIV,
        S_MIX_MUL,
        S_MIX_ADD,
        S_DONE
    } state_t;

endpackage
`default_nettype wire

@@ hw/rtl/kli_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
module kli_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

@@ hw/rtl/kli_mix.sv @@
`timescale 1ns / 1ps
`default_nettype none
module kli_mix (
    input  wire logic               clk,
    input  wire logic signed [32:0] diff,
    input  wire logic        [15:0] frac,
    input  wire logic signed [31:0] base,
    output logic signed      [31:0] result
);

    logic signed [49:0] prod_reg;
    logic signed [49:0] prod_next;
    logic signed [33:0] sum;

    assign prod_next = 50'(diff) * 50'($signed({1'b0, frac}));

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    assign sum    = 34'(base) + 34'(prod_reg >>> 16);
    assign result = sum[31:0];

endmodule
`default_nettype wire

@@ hw/rtl/kli_div.sv @@
`timescale 1ns / 1ps
`default_nettype none
module kli_div (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [31:0] num,
    input  wire logic [31:0] den,
    output logic             busy,
    output logic      [15:0] quot
);

    logic [32:0] rem_reg;
    logic [32:0] rem_next;
    logic [15:0] quot_reg;
    logic [15:0] quot_next;
    logic [4:0]  cnt_reg;
    logic [4:0]  cnt_next;
    logic [33:0] trial;

    assign trial = {rem_reg, 1'b0} - {2'b0, den};

    always_comb
    begin
        rem_next  = rem_reg;
        quot_next = quot_reg;
        cnt_next  = cnt_reg;
        if (start)
        begin
            rem_next  = {1'b0, num};
            quot_next = '0;
            cnt_next  = 5'd16;
        end
        else if (cnt_reg != 5'd0)
        begin
            cnt_next = cnt_reg - 5'd1;
            if (!trial[33])
            begin
                rem_next  = trial[32:0];
                quot_next = {quot_reg[14:0], 1'b1};
            end
            else
            begin
                rem_next  = {rem_reg[31:0], 1'b0};
                quot_next = {quot_reg[14:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
    end

    assign busy = (cnt_reg != 5'd0);
    assign quot = quot_reg;

endmodule
`default_nettype wire

@@ hw/rtl/keyframe_linear_interpolator.sv @@
`timescale 1ns / 1ps
`default_nettype none
// One request is taken at a time and ready stays low until its response has been taken. An
// add scans the table for a duplicate and the insertion point, then moves every later node
// up one slot. A query scans for the bracketing nodes, runs a sixteen-step restoring divider
// for the fraction and then mixes the eight channels one after another through one shared
// multiplier; a node whose key matches exactly is returned as it is. The table sits in one
// node memory with a registered read.
module keyframe_linear_interpolator
    import kli_pkg::*;
#(
    parameter int MAX_NODES = MAX_NODES_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic cfg_we,
    input  wire logic cfg_wdata,
    input  wire logic in_valid,
    output logic      in_ready,
    input  wire req_t in_data,
    output logic      out_valid,
    input  wire logic out_ready,
    output rsp_t      out_data
);

    localparam int AW = $clog2(MAX_NODES);
    localparam int CW = $clog2(MAX_NODES + 1);

    state_t          state_reg, state_next;
    logic            frozen_reg;
    logic [CW-1:0]   count_reg, count_next;
    logic [CW-1:0]   idx_reg, idx_next;
    logic [CW-1:0]   pos_reg, pos_next;
    logic            found_reg, found_next;
    logic [3:0]      ch_reg, ch_next;
    req_t            req_reg;
    logic [31:0]     key_reg, key_next;
    logic [31:0]     k0_reg, k0_next;
    logic [NODE_W-1:0] na_reg, na_next;
    logic [NODE_W-1:0] nb_reg, nb_next;
    rsp_t            rsp_reg, rsp_next;

    logic            ram_we;
    logic [AW-1:0]   ram_waddr, ram_raddr;
    logic [NODE_W-1:0] ram_wdata, ram_rdata;
    logic [31:0]     rd_key;

    logic            div_start, div_busy;
    logic [15:0]     div_q;
    logic signed [32:0] mix_diff;
    logic signed [31:0] mix_base, mix_res;
    logic [31:0]     frozen_key;

    kli_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_ram (
        .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
        .raddr(ram_raddr), .rdata(ram_rdata)
    );

    kli_div u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start),
        .num(req_reg.key_tick - k0_reg), .den(key_reg - k0_reg),
        .busy(div_busy), .quot(div_q)
    );

    kli_mix u_mix (
        .clk(clk), .diff(mix_diff), .frac(div_q), .base(mix_base), .result(mix_res)
    );

    assign rd_key     = ram_rdata[NODE_W-1 -: 32];
    assign frozen_key = 32'(32'(count_reg) * FROZEN_STEP);

    always_comb
    begin
        mix_diff = '0;
        mix_base = '0;
        case (ch_reg)
            4'd0: begin mix_base = $signed(na_reg[191:160]);
                mix_diff = 33'($signed(nb_reg[191:160])) - 33'($signed(na_reg[191:160])); end
            4'd1: begin mix_base = $signed(na_reg[159:128]);
                mix_diff = 33'($signed(nb_reg[159:128])) - 33'($signed(na_reg[159:128])); end
            4'd2: begin mix_base = $signed(na_reg[127:96]);
                mix_diff = 33'($signed(nb_reg[127:96])) - 33'($signed(na_reg[127:96])); end
            4'd3: begin mix_base = 32'($signed(na_reg[95:80]));
                mix_diff = 33'($signed(nb_reg[95:80])) - 33'($signed(na_reg[95:80])); end
            4'd4: begin mix_base = 32'($signed(na_reg[79:64]));
                mix_diff = 33'($signed(nb_reg[79:64])) - 33'($signed(na_reg[79:64])); end
            4'd5: begin mix_base = 32'($signed(na_reg[63:48]));
                mix_diff = 33'($signed(nb_reg[63:48])) - 33'($signed(na_reg[63:48])); end
            4'd6: begin mix_base = 32'($signed(na_reg[47:32]));
                mix_diff = 33'($signed(nb_reg[47:32])) - 33'($signed(na_reg[47:32])); end
            4'd7: begin mix_base = $signed({16'b0, na_reg[31:16]});
                mix_diff = 33'({1'b0, nb_reg[31:16]}) - 33'({1'b0, na_reg[31:16]}); end
            default: ;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        idx_next   = idx_reg;
        pos_next   = pos_reg;
        found_next = found_reg;
        ch_next    = ch_reg;
        key_next   = key_reg;
        k0_next    = k0_reg;
        na_next    = na_reg;
        nb_next    = nb_reg;
        rsp_next   = rsp_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    rsp_next = '0;
                    idx_next = '0;
                    found_next = 1'b0;
                    pos_next = count_reg;
                    key_next = frozen_reg ? frozen_key : in_data.key_tick;
                    unique case (action_t'(in_data.action))
                        ACT_ADD:   state_next = S_ADD_RD;
                        ACT_QUERY:
                        begin
                            if (count_reg < CW'(2))
                            begin
                                rsp_next.status = ST_FEW;
                                state_next = S_DONE;
                            end
                            else
                            begin
                                state_next = S_Q_RD;
                            end
                        end
                        ACT_CLEAR:
                        begin
                            count_next = '0;
                            state_next = S_DONE;
                        end
                        default:   state_next = S_DONE;
                    endcase
                end
            end
            S_ADD_RD:
            begin
                if (idx_reg == count_reg)
                begin
                    if (count_reg == CW'(MAX_NODES))
                    begin
                        rsp_next.status = ST_FULL;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        idx_next = count_reg;
                        state_next = (pos_reg == count_reg) ? S_INS : S_SHIFT_RD;
                    end
                end
                else
                begin
                    state_next = S_ADD_CHK;
                end
            end
            S_ADD_CHK:
            begin
                if (rd_key == key_reg)
                begin
                    rsp_next.status = ST_DUP;
                    state_next = S_DONE;
                end
                else
                begin
                    if (!found_reg && !(rd_key < key_reg))
                    begin
                        found_next = 1'b1;
                        pos_next = idx_reg;
                    end
                    idx_next = idx_reg + CW'(1);
                    state_next = S_ADD_RD;
                end
            end
            S_SHIFT_RD: state_next = S_SHIFT_WR;
            S_SHIFT_WR:
            begin
                idx_next = idx_reg - CW'(1);
                state_next = (idx_reg - CW'(1) == pos_reg) ? S_INS : S_SHIFT_RD;
            end
            S_INS:
            begin
                count_next = count_reg + CW'(1);
                state_next = S_DONE;
            end
            S_Q_RD: state_next = S_Q_CHK;
            S_Q_CHK:
            begin
                if (idx_reg == '0 && rd_key > req_reg.key_tick)
                begin
                    rsp_next.status = ST_RANGE;
                    state_next = S_DONE;
                end
                else if (rd_key == req_reg.key_tick)
                begin
                    nb_next = ram_rdata;
                    rsp_next.out_pos_x = $signed(ram_rdata[191:160]);
                    rsp_next.out_pos_y = $signed(ram_rdata[159:128]);
                    rsp_next.out_pos_z = $signed(ram_rdata[127:96]);
                    rsp_next.out_rot_w = $signed(ram_rdata[95:80]);
                    rsp_next.out_rot_x = $signed(ram_rdata[79:64]);
                    rsp_next.out_rot_y = $signed(ram_rdata[63:48]);
                    rsp_next.out_rot_z = $signed(ram_rdata[47:32]);
                    rsp_next.out_view_angle = ram_rdata[31:16];
                    state_next = S_DONE;
                end
                else if (rd_key > req_reg.key_tick)
                begin
                    key_next = rd_key;
                    nb_next = ram_rdata;
                    state_next = S_Q_RDA;
                end
                else if (idx_reg + CW'(1) == count_reg)
                begin
                    rsp_next.status = ST_RANGE;
                    state_next = S_DONE;
                end
                else
                begin
                    idx_next = idx_reg + CW'(1);
                    state_next = S_Q_RD;
                end
            end
            S_Q_RDA:
            begin
                idx_next = idx_reg - CW'(1);
                state_next = S_Q_RDB;
            end
            S_Q_RDB: state_next = S_Q_LDB;
            S_Q_LDB:
            begin
                na_next = ram_rdata;
                k0_next = rd_key;
                ch_next = '0;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (!div_busy && ch_reg == 4'd1)
                begin
                    ch_next = '0;
                    state_next = S_MIX_MUL;
                end
                else
                begin
                    ch_next = 4'd1;
                end
            end
            S_MIX_MUL: state_next = S_MIX_ADD;
            S_MIX_ADD:
            begin
                case (ch_reg)
                    4'd0: rsp_next.out_pos_x = mix_res;
                    4'd1: rsp_next.out_pos_y = mix_res;
                    4'd2: rsp_next.out_pos_z = mix_res;
                    4'd3: rsp_next.out_rot_w = mix_res[15:0];
                    4'd4: rsp_next.out_rot_x = mix_res[15:0];
                    4'd5: rsp_next.out_rot_y = mix_res[15:0];
                    4'd6: rsp_next.out_rot_z = mix_res[15:0];
                    default: rsp_next.out_view_angle = mix_res[15:0];
                endcase
                ch_next = ch_reg + 4'd1;
                state_next = (ch_reg == 4'd7) ? S_DONE : S_MIX_MUL;
            end
            S_DONE:
            begin
                if (out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = idx_reg[AW-1:0];
        ram_raddr = idx_reg[AW-1:0];
        ram_wdata = ram_rdata;
        div_start = 1'b0;
        unique case (state_reg)
            S_SHIFT_RD: ram_raddr = AW'(idx_reg - CW'(1));
            S_SHIFT_WR: ram_we = 1'b1;
            S_INS:
            begin
                ram_we    = 1'b1;
                ram_waddr = pos_reg[AW-1:0];
                ram_wdata = {key_reg, req_reg.pos_x, req_reg.pos_y, req_reg.pos_z,
                             req_reg.rot_w, req_reg.rot_x, req_reg.rot_y, req_reg.rot_z,
                             req_reg.view_angle, 16'b0};
            end
            S_DIV: div_start = (ch_reg == 4'd0);
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            frozen_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (cfg_we)
            begin
                frozen_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE)
        begin
            req_reg <= in_data;
        end
        idx_reg   <= idx_next;
        pos_reg   <= pos_next;
        found_reg <= found_next;
        ch_reg    <= ch_next;
        key_reg   <= key_next;
        k0_reg    <= k0_next;
        na_reg    <= na_next;
        nb_reg    <= nb_next;
        rsp_reg   <= rsp_next;
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_DONE);
    assign out_data  = rsp_reg;

endmodule
`default_nettype wire
